[rtl/chlzss_pkg.sv]
// types and constants shared by the chunked lzss decoder
package chlzss_pkg;

    // one transfer on the packed stream side
    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_file;
    } strm_item_t;

    // one transfer on the decoded side
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } dec_item_t;

    // framing phase, one-hot
    typedef enum logic [5:0] {
        PH_HDR_HI   = 6'b000001,
        PH_HDR_LO   = 6'b000010,
        PH_STORED   = 6'b000100,
        PH_FLAG     = 6'b001000,
        PH_TOKEN    = 6'b010000,
        PH_MATCH_HI = 6'b100000
    } phase_t;

    // byte returned for a window entry not written in this chunk
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    // shortest match, added to the 4-bit length code
    localparam logic [4:0] MATCH_MIN = 5'd3;
    // longest match; the window restarts this far below its top
    localparam int MATCH_MAX = 18;
    // high byte loaded into the flag register so eight shifts can be counted
    localparam logic [7:0] FLAG_FILL = 8'hFF;

endpackage

[rtl/chunked_lzss_decoder.sv]
// chunked lzss decoder: framing, window memory and match copy engine
//
// Decodes a chunked packed stream taken one byte per transfer. A match byte
// starts a copy of 3 to 18 bytes and stalls the stream side until the copy
// is done: the window memory has a registered read, and the copy engine issues
// one window read per cycle and writes back and emits one byte per cycle while
// the decoded side does not stall, forwarding a byte to a read of the entry it
// is writing in the same cycle. Stalls on the decoded side hold the engine.
// Entries not yet written in the current chunk read as spaces; this is tracked
// by a fill count from the chunk start position, so there is no clearing pass
// and the block is ready straight after reset.
module chunked_lzss_decoder
    import chlzss_pkg::*;
#(
    parameter int WINDOW_SIZE = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       strm_valid,
    output logic       strm_stall,
    input  strm_item_t strm,
    output logic       dec_valid,
    input  logic       dec_stall,
    output dec_item_t  dec
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam logic [AW-1:0] WIN_START = AW'(WINDOW_SIZE - MATCH_MAX);
    localparam logic [AW:0] FILL_FULL = (AW+1)'(WINDOW_SIZE);

    // window memory
    logic [7:0] win_mem [WINDOW_SIZE];
    logic [7:0] rd_data_reg;

    // framing state
    phase_t        phase_reg, phase_next;
    logic [15:0]   flag_reg, flag_next;
    logic [14:0]   left_reg, left_next;
    logic [7:0]    hdr_hi_reg, hdr_hi_next;
    logic [7:0]    off_lo_reg, off_lo_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW:0]   fill_reg, fill_next;

    // copy engine state
    logic [AW-1:0] src_reg, src_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          rdv_reg, rdv_next;
    logic          rlast_reg, rlast_next;
    logic          rval_reg, rval_next;
    logic          fwd_reg, fwd_next;
    logic [7:0]    fwd_data_reg, fwd_data_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    dec_item_t out_reg, out_next;

    logic          out_free, busy, in_fire, emit, issue;
    logic [7:0]    emit_val;
    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;
    phase_t        ph_eff;
    logic [15:0]   hdr;
    logic [14:0]   left_dec;
    logic [15:0]   flag_shift;
    logic [AW-1:0] src_rel;

    assign out_free   = !out_valid_reg || !dec_stall;
    assign busy       = (cnt_reg != 5'd0) || rdv_reg;
    assign strm_stall = busy || !out_free;
    assign in_fire    = strm_valid && !strm_stall;
    assign emit       = rdv_reg && out_free;
    assign issue      = (cnt_reg != 5'd0) && (!rdv_reg || emit);
    assign emit_val   = fwd_reg ? fwd_data_reg : (rval_reg ? rd_data_reg : SPACE_CHAR);
    assign dec_valid  = out_valid_reg;
    assign dec        = out_reg;

    // framing and copy engine next state
    always_comb
    begin
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        left_next      = left_reg;
        hdr_hi_next    = hdr_hi_reg;
        off_lo_next    = off_lo_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        rdv_next       = rdv_reg;
        rlast_next     = rlast_reg;
        rval_next      = rval_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg && dec_stall;
        out_next       = out_reg;
        we             = 1'b0;
        wa             = wp_reg;
        wd             = strm.in_byte;
        ph_eff         = strm.new_file ? PH_HDR_HI : phase_reg;
        hdr            = {hdr_hi_reg, strm.in_byte};
        left_dec       = left_reg - 15'd1;
        flag_shift     = {1'b0, flag_reg[15:1]};
        src_rel        = '0;

        // accepted stream byte
        if (in_fire)
        begin
            case (ph_eff)
                PH_HDR_HI:
                begin
                    hdr_hi_next = strm.in_byte;
                    phase_next  = PH_HDR_LO;
                end
                PH_HDR_LO:
                begin
                    left_next = hdr[14:0];
                    if (hdr[14:0] == 15'd0)
                    begin
                        phase_next = PH_HDR_HI;
                    end
                    else if (hdr[15])
                    begin
                        phase_next = PH_STORED;
                    end
                    else
                    begin
                        fill_next  = '0;
                        wp_next    = WIN_START;
                        flag_next  = '0;
                        phase_next = PH_FLAG;
                    end
                end
                PH_STORED:
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: strm.in_byte, run_last: 1'b1};
                    left_next      = left_dec;
                    if (left_dec == 15'd0)
                    begin
                        phase_next = PH_HDR_HI;
                    end
                end
                PH_FLAG:
                begin
                    flag_next  = {FLAG_FILL, strm.in_byte};
                    left_next  = left_dec;
                    phase_next = (left_dec == 15'd0) ? PH_HDR_HI : PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (flag_reg[0])
                    begin
                        // literal: emit, store, then move to the next token
                        out_valid_next = 1'b1;
                        out_next       = '{out_byte: strm.in_byte, run_last: 1'b1};
                        we             = 1'b1;
                        wp_next        = wp_reg + 1'b1;
                        fill_next      = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
                        left_next      = left_dec;
                        if (left_dec == 15'd0)
                        begin
                            phase_next = PH_HDR_HI;
                        end
                        else
                        begin
                            flag_next  = flag_shift;
                            phase_next = flag_shift[8] ? PH_TOKEN : PH_FLAG;
                        end
                    end
                    else if (left_reg <= 15'd1)
                    begin
                        // match cut by the chunk end
                        left_next  = '0;
                        phase_next = PH_HDR_HI;
                    end
                    else
                    begin
                        off_lo_next = strm.in_byte;
                        left_next   = left_dec;
                        phase_next  = PH_MATCH_HI;
                    end
                end
                PH_MATCH_HI:
                begin
                    // start the copy engine, framing moves on at once
                    src_next  = AW'({strm.in_byte[7:4], off_lo_reg});
                    cnt_next  = {1'b0, strm.in_byte[3:0]} + MATCH_MIN;
                    left_next = left_dec;
                    if (left_dec == 15'd0)
                    begin
                        phase_next = PH_HDR_HI;
                    end
                    else
                    begin
                        flag_next  = flag_shift;
                        phase_next = flag_shift[8] ? PH_TOKEN : PH_FLAG;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR_HI;
                end
            endcase
        end

        // copy engine: write back and emit the byte from the last window read
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = '{out_byte: emit_val, run_last: rlast_reg};
            we             = 1'b1;
            wd             = emit_val;
            wp_next        = wp_reg + 1'b1;
            fill_next      = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
            rdv_next       = 1'b0;
        end

        // copy engine: issue the next window read
        if (issue)
        begin
            src_rel       = src_reg - WIN_START;
            src_next      = src_reg + 1'b1;
            cnt_next      = cnt_reg - 5'd1;
            rdv_next      = 1'b1;
            rlast_next    = (cnt_reg == 5'd1);
            rval_next     = ({1'b0, src_rel} < fill_next);
            fwd_next      = emit && (src_reg == wp_reg);
            fwd_data_next = emit_val;
        end
    end

    // window memory ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            win_mem[wa] <= wd;
        end
        if (issue)
        begin
            rd_data_reg <= win_mem[src_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR_HI;
            flag_reg      <= '0;
            left_reg      <= '0;
            hdr_hi_reg    <= '0;
            off_lo_reg    <= '0;
            wp_reg        <= WIN_START;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            left_reg      <= left_next;
            hdr_hi_reg    <= hdr_hi_next;
            off_lo_reg    <= off_lo_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        rlast_reg    <= rlast_next;
        rval_reg     <= rval_next;
        fwd_reg      <= fwd_next;
        fwd_data_reg <= fwd_data_next;
        out_reg      <= out_next;
    end

endmodule

[verif/tb_chunked_lzss_decoder.sv]
// testbench for the chunked lzss decoder: directed and random streams checked byte by byte
`timescale 1ns / 100ps

module tb_chunked_lzss_decoder;
    import chlzss_pkg::*;

    localparam int WIN_SIZE = 4096;
    localparam logic [11:0] WIN_START = 12'(WIN_SIZE - MATCH_MAX);
    localparam int RANDOM_ITEMS = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       strm_valid = 1'b0;
    logic       strm_stall;
    strm_item_t strm = '0;
    logic       dec_valid;
    logic       dec_stall = 1'b0;
    dec_item_t  dec;

    // decoder state as the stream should leave it
    logic [7:0]  hist_byte [WIN_SIZE];
    logic        hist_seen [WIN_SIZE];
    logic [11:0] hist_wr;
    logic [15:0] flag_sr;
    logic [14:0] body_left;
    phase_t      frame_ph;
    logic [7:0]  hdr_hi;
    logic [7:0]  ofs_lo;

    dec_item_t decoded_q [$];
    dec_item_t dec_seen_q [$];

    int unsigned n_sent = 0;
    int unsigned n_random = 0;
    int unsigned n_chunks = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    logic        hold_req = 1'b0;
    logic        quiet = 1'b0;

    chunked_lzss_decoder #(
        .WINDOW_SIZE(WIN_SIZE)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .strm_valid(strm_valid),
        .strm_stall(strm_stall),
        .strm(strm),
        .dec_valid(dec_valid),
        .dec_stall(dec_stall),
        .dec(dec)
    );

    always #2 clk = ~clk;

    // idle length: none most of the time, mostly short, a few long
    function automatic int pick_gap(int pct);
        int r;
        if (quiet || $urandom_range(99) >= pct)
            return 0;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void clear_decoder();
        foreach (hist_byte[i])
        begin
            hist_byte[i] = '0;
            hist_seen[i] = 1'b0;
        end
        hist_wr = WIN_START;
        flag_sr = '0;
        body_left = '0;
        frame_ph = PH_HDR_HI;
        hdr_hi = '0;
        ofs_lo = '0;
    endfunction

    // queue one decoded byte, optionally recording it in the history window
    function automatic void add_decoded(logic [7:0] v, logic last, logic to_hist);
        dec_item_t d;
        d.out_byte = v;
        d.run_last = last;
        decoded_q.push_back(d);
        if (to_hist)
        begin
            hist_byte[hist_wr] = v;
            hist_seen[hist_wr] = 1'b1;
            hist_wr = hist_wr + 12'd1;
        end
    endfunction

    // one body byte used up: end of chunk or on to the next flag bit
    function automatic void token_done();
        body_left = body_left - 15'd1;
        if (body_left == '0)
            frame_ph = PH_HDR_HI;
        else
        begin
            flag_sr = flag_sr >> 1;
            frame_ph = flag_sr[8] ? PH_TOKEN : PH_FLAG;
        end
    endfunction

    // expected decoded bytes for one accepted stream byte
    function automatic void decode_byte(strm_item_t it);
        logic [15:0] hdr;
        logic [11:0] src;
        logic [4:0]  len;
        logic [7:0]  v;
        if (it.new_file)
            frame_ph = PH_HDR_HI;
        case (frame_ph)
            PH_HDR_HI:
            begin
                hdr_hi = it.in_byte;
                frame_ph = PH_HDR_LO;
            end
            PH_HDR_LO:
            begin
                hdr = {hdr_hi, it.in_byte};
                body_left = hdr[14:0];
                if (body_left == '0)
                    frame_ph = PH_HDR_HI;
                else if (hdr[15])
                    frame_ph = PH_STORED;
                else
                begin
                    foreach (hist_seen[i])
                        hist_seen[i] = 1'b0;
                    hist_wr = WIN_START;
                    flag_sr = '0;
                    frame_ph = PH_FLAG;
                end
            end
            PH_STORED:
            begin
                add_decoded(it.in_byte, 1'b1, 1'b0);
                body_left = body_left - 15'd1;
                if (body_left == '0)
                    frame_ph = PH_HDR_HI;
            end
            PH_FLAG:
            begin
                flag_sr = {FLAG_FILL, it.in_byte};
                body_left = body_left - 15'd1;
                frame_ph = (body_left == '0) ? PH_HDR_HI : PH_TOKEN;
            end
            PH_TOKEN:
            begin
                if (flag_sr[0])
                begin
                    add_decoded(it.in_byte, 1'b1, 1'b1);
                    token_done();
                end
                else if (body_left <= 15'd1)
                begin
                    // match cut by the chunk end: dropped
                    body_left = '0;
                    frame_ph = PH_HDR_HI;
                end
                else
                begin
                    ofs_lo = it.in_byte;
                    body_left = body_left - 15'd1;
                    frame_ph = PH_MATCH_HI;
                end
            end
            PH_MATCH_HI:
            begin
                src = {it.in_byte[7:4], ofs_lo};
                len = MATCH_MIN + 5'(it.in_byte[3:0]);
                for (int i = 0; i < len; i++)
                begin
                    v = hist_seen[src] ? hist_byte[src] : SPACE_CHAR;
                    add_decoded(v, (i == len - 1), 1'b1);
                    src = src + 12'd1;
                end
                token_done();
            end
            default:
                frame_ph = PH_HDR_HI;
        endcase
    endfunction

    // offer one stream byte after a random gap and wait for its transfer
    task automatic send_byte(input logic [7:0] b, input logic nf);
        int         gap;
        strm_item_t it;
        gap = pick_gap(40);
        it.in_byte = b;
        it.new_file = nf;
        if (gap > 0)
        begin
            strm_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        strm_valid <= 1'b1;
        strm <= it;
        @(posedge clk);
        while (strm_stall)
            @(posedge clk);
        decode_byte(it);
        n_sent++;
    endtask

    // stop offering and wait until every decoded byte has come back
    task automatic drain_stream();
        strm_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // feed body bytes of the open chunk, steered by the framing state
    task automatic send_body(input int max_bytes);
        logic [11:0] tgt;
        logic [7:0]  b;
        int          cnt;
        int          r;
        tgt = 12'($urandom);
        cnt = 0;
        while (frame_ph != PH_HDR_HI && frame_ph != PH_HDR_LO && cnt < max_bytes)
        begin
            case (frame_ph)
                PH_FLAG:
                begin
                    r = $urandom_range(9);
                    b = (r < 3) ? 8'hFF : (r == 3) ? 8'h00 : 8'($urandom);
                end
                PH_TOKEN:
                begin
                    if (flag_sr[0])
                        b = 8'($urandom);
                    else
                    begin
                        // mostly point back into bytes this chunk has written
                        if ($urandom_range(3) != 0)
                            tgt = hist_wr - 12'($urandom_range(1, 24));
                        else
                            tgt = 12'($urandom);
                        b = tgt[7:0];
                    end
                end
                PH_MATCH_HI:
                    b = {tgt[11:8], 4'($urandom_range(15))};
                default:
                    b = 8'($urandom);
            endcase
            // broken chunk: restart framing part way through
            if ($urandom_range(99) < 2)
            begin
                send_byte(b, 1'b1);
                return;
            end
            send_byte(b, 1'b0);
            cnt++;
        end
    endtask

    task automatic send_header(input logic stored, input int unsigned body_len);
        logic [15:0] hdr;
        hdr = {stored, 15'(body_len)};
        send_byte(hdr[15:8], (frame_ph != PH_HDR_HI) || ($urandom_range(3) == 0));
        send_byte(hdr[7:0], 1'b0);
        n_chunks++;
    endtask

    task automatic send_chunk(input logic stored, input int unsigned body_len);
        send_header(stored, body_len);
        send_body(body_len);
    endtask

    function automatic int unsigned lzss_len();
        return ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
    endfunction

    // stored chunks, empty chunks and the extreme byte values
    task automatic test_stored_chunks();
        send_byte(8'h80, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        n_chunks += 3;
    endtask

    // longest match over unwritten entries, top offset, match cut by chunk end
    task automatic test_lzss_specials();
        send_byte(8'h00, 1'b1);
        send_byte(8'h07, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h12, 1'b0);
        n_chunks++;
    endtask

    // new file inside a long stored chunk, then a chunk ended by its flag byte
    task automatic test_restart();
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        n_chunks += 2;
    endtask

    task automatic test_random_stream();
        int unsigned start;
        int          r;
        start = n_sent;
        while (n_sent - start < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 60)
                send_chunk(1'b0, lzss_len());
            else if (r < 75)
                send_chunk(1'b1, $urandom_range(0, 6));
            else if (r < 85)
                send_chunk(1'($urandom_range(1)), 0);
            else
            begin
                // loose bytes with no framing in mind
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), ($urandom_range(3) == 0));
            end
        end
        n_random = n_sent - start;
    endtask

    // no gaps on either side for a while
    task automatic test_back_to_back();
        quiet = 1'b1;
        send_chunk(1'b0, 12);
        send_chunk(1'b1, 4);
        send_chunk(1'b0, 8);
        quiet = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering chunk data
    task automatic test_receiver_hold();
        quiet = 1'b1;
        hold_req <= 1'b1;
        send_header(1'b0, 20);
        send_body(20);
        quiet = 1'b0;
    endtask

    // sender stops part way through a chunk until everything has drained
    task automatic test_pause_mid_chunk();
        send_header(1'b0, 16);
        send_body(6);
        drain_stream();
        send_body(16);
        drain_stream();
    endtask

    function automatic void log_error(string what, dec_item_t want, dec_item_t got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%s: expected byte %02h last %0b, got byte %02h last %0b",
                     what, want.out_byte, want.run_last, got.out_byte, got.run_last);
    endfunction

    // sample decoded transfers and drive the receiver stall
    always @(posedge clk)
    begin
        if (rst_n && dec_valid && !dec_stall)
            dec_seen_q.push_back(dec);
        if (hold_req)
        begin
            hold_req <= 1'b0;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            dec_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            stall_left = pick_gap(20);
            dec_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // compare sampled transfers with the oldest expected bytes
    always @(negedge clk)
    begin
        dec_item_t got;
        dec_item_t want;
        while (dec_seen_q.size() > 0)
        begin
            got = dec_seen_q.pop_front();
            n_checked++;
            if (decoded_q.size() == 0)
                log_error("unexpected byte", '0, got);
            else
            begin
                want = decoded_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    log_error("byte mismatch", want, got);
                else if (got.run_last !== want.run_last)
                    log_error("run end mismatch", want, got);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((strm_valid && !strm_stall) || (dec_valid && !dec_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
                     idle_cycles, decoded_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clear_decoder();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stored_chunks();
        test_lzss_specials();
        test_restart();
        test_random_stream();
        test_back_to_back();
        test_receiver_hold();
        test_pause_mid_chunk();

        // wait out the last results and any late extras
        strm_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (decoded_q.size() != 0)
        begin
            $display("%0d expected bytes never arrived", decoded_q.size());
            n_errors += decoded_q.size();
        end

        $display("covered %0d stream bytes in about %0d chunks, %0d of them random",
                 n_sent, n_chunks, n_random);
        $display("checked %0d decoded bytes, incl. a %0d-cycle receiver hold and a drain",
                 n_checked, HOLD_CYCLES);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
